FILE: hw/rtl/cgdrs_pkg.sv
// cgdrs_pkg: shared types, codes and reset constants of the CV/gate DAC
// refresh scheduler. No dependencies; used by the interfaces and all modules.
`default_nettype none

package cgdrs_pkg;

  // Number of control-voltage channels (fixed by the two-chip DAC layout)
  localparam int unsigned CvChannelsDefault = 4;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned CvW    = 12;
  localparam int unsigned TgtW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  localparam logic [CvW-1:0]   CvWantedReset = 12'h800;
  localparam logic [CvW-1:0]   CvSentReset   = 12'hfff;
  localparam logic [ByteW-1:0] GateWantedReset = 8'h00;
  localparam logic [ByteW-1:0] GateSentReset   = 8'hff;

  // DAC frame heads for even and odd CV channels on a chip
  localparam logic [ByteW-1:0] DacHeadEven = 8'h30;
  localparam logic [ByteW-1:0] DacHeadOdd  = 8'hb0;

  // Gate word bit masks
  localparam logic [ByteW-1:0] GateMaskBeep  = 8'h01;
  localparam logic [ByteW-1:0] GateMaskClock = 8'h40;
  localparam logic [ByteW-1:0] GateMaskReset = 8'h80;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_CV   = 3'd1,
    CMD_SET_GATE = 3'd2,
    CMD_SET_CLK  = 3'd3,
    CMD_SET_RST  = 3'd4,
    CMD_SET_BEEP = 3'd5
  } cmd_e;

  typedef enum logic [TgtW-1:0] {
    TGT_DAC0 = 2'd0,
    TGT_DAC1 = 2'd1,
    TGT_GATE = 2'd2
  } target_e;

  // One command transaction as held in the input register
  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ChanW-1:0] channel;
    logic [CvW-1:0]   value;
    logic             link_ready;
  } cmd_t;

  // One frame transaction
  typedef struct packed {
    logic [TgtW-1:0]  target_select;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
  } frame_t;

  // Result of the scheduler core for the item in the input register
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } result_t;

  // Gate word bit for a gate channel (bit 2 is never used)
  function automatic logic [ByteW-1:0] gate_mask(input logic [ChanW-1:0] ch);
    logic [ByteW-1:0] m;
    unique case (ch)
      2'd0:    m = 8'h02;
      2'd1:    m = 8'h08;
      2'd2:    m = 8'h10;
      default: m = 8'h20;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cgdrs_cmd_if.sv
// cgdrs_cmd_if: valid/ready channel carrying one command transaction.
// Depends on cgdrs_pkg for field widths.
`default_nettype none

interface cgdrs_cmd_if;
  import cgdrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [ChanW-1:0] channel;
  logic [CvW-1:0]   value;
  logic             link_ready;

  modport source (output valid, command, channel, value, link_ready, input ready);
  modport sink   (input valid, command, channel, value, link_ready, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cgdrs_frame_if.sv
// cgdrs_frame_if: valid/ready channel carrying one link frame transaction.
// Depends on cgdrs_pkg for field widths.
`default_nettype none

interface cgdrs_frame_if;
  import cgdrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [TgtW-1:0]  target_select;
  logic [ByteW-1:0] first_byte;
  logic [ByteW-1:0] second_byte;

  modport source (output valid, target_select, first_byte, second_byte, input ready);
  modport sink   (input valid, target_select, first_byte, second_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cgdrs_core.sv
// cgdrs_core: wanted/sent state of the CV channels and gate word, the tick
// phase, and the frame decision for one command. Depends on cgdrs_pkg.
`default_nettype none

module cgdrs_core #(
  parameter int unsigned CvChannels = cgdrs_pkg::CvChannelsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cgdrs_pkg::cmd_t  item_i,
  input  wire logic             commit_i,
  output cgdrs_pkg::result_t    result_o
);
  import cgdrs_pkg::*;

  logic [CvW-1:0]    cv_wanted_q [CvChannels];
  logic [CvW-1:0]    cv_sent_q   [CvChannels];
  logic [ByteW-1:0]  gate_wanted_q, gate_wanted_d;
  logic [ByteW-1:0]  gate_sent_q, gate_sent_d;
  logic              beep_q, beep_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  logic              is_tick;
  logic              odd_phase;
  logic [ChanW-1:0]  tick_ch;
  logic              tick_ch_ok;
  logic              set_ch_ok;
  logic [CvW-1:0]    cv_cur;
  logic              cv_changed;
  logic [ByteW-1:0]  gate_refresh;
  logic              on;
  logic              cv_send;
  logic              gate_send;

  assign is_tick    = (cmd_e'(item_i.command) == CMD_TICK) && item_i.link_ready;
  assign odd_phase  = phase_q[0];
  assign tick_ch    = phase_q[PhaseW-1:1];
  assign tick_ch_ok = 32'(tick_ch) < CvChannels;
  assign set_ch_ok  = 32'(item_i.channel) < CvChannels;
  assign on         = item_i.value != '0;

  // Compare the phase's CV channel against what was last sent
  always_comb begin
    cv_cur     = cv_wanted_q[tick_ch];
    cv_changed = tick_ch_ok && (cv_sent_q[tick_ch] != cv_cur);
  end

  // Refresh the beep bit: on at phases 3 and 7 while the beep is enabled
  assign gate_refresh = (gate_wanted_q & ~GateMaskBeep) |
                        ((beep_q && phase_q[1]) ? GateMaskBeep : '0);

  assign cv_send   = is_tick && !odd_phase && cv_changed;
  assign gate_send = is_tick && odd_phase && (gate_sent_q != gate_refresh);

  // Build the frame
  always_comb begin
    result_o = '0;
    if (cv_send) begin
      result_o.valid = 1'b1;
      result_o.frame.target_select = tick_ch[1] ? TGT_DAC1 : TGT_DAC0;
      result_o.frame.first_byte    = (tick_ch[0] ? DacHeadOdd : DacHeadEven) |
                                     {4'h0, cv_cur[CvW-1:8]};
      result_o.frame.second_byte   = cv_cur[7:0];
    end else if (gate_send) begin
      result_o.valid = 1'b1;
      result_o.frame.target_select = TGT_GATE;
      result_o.frame.first_byte    = '0;
      result_o.frame.second_byte   = gate_refresh;
    end
  end

  // Next state of the scalar registers
  always_comb begin
    gate_wanted_d = gate_wanted_q;
    gate_sent_d   = gate_sent_q;
    beep_d        = beep_q;
    phase_d       = phase_q;
    unique case (cmd_e'(item_i.command))
      CMD_TICK: begin
        if (item_i.link_ready) begin
          phase_d = phase_q + 1'b1;
          if (odd_phase) begin
            gate_wanted_d = gate_refresh;
            gate_sent_d   = gate_refresh;
          end
        end
      end
      CMD_SET_GATE: begin
        gate_wanted_d = on ? (gate_wanted_q | gate_mask(item_i.channel))
                           : (gate_wanted_q & ~gate_mask(item_i.channel));
      end
      CMD_SET_CLK: begin
        gate_wanted_d = on ? (gate_wanted_q | GateMaskClock)
                           : (gate_wanted_q & ~GateMaskClock);
      end
      CMD_SET_RST: begin
        gate_wanted_d = on ? (gate_wanted_q | GateMaskReset)
                           : (gate_wanted_q & ~GateMaskReset);
      end
      CMD_SET_BEEP: beep_d = on;
      default: ;
    endcase
  end

  // Hold scalar state; advance only on a committed command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_wanted_q <= GateWantedReset;
      gate_sent_q   <= GateSentReset;
      beep_q        <= 1'b0;
      phase_q       <= '0;
    end else if (commit_i) begin
      gate_wanted_q <= gate_wanted_d;
      gate_sent_q   <= gate_sent_d;
      beep_q        <= beep_d;
      phase_q       <= phase_d;
    end
  end

  // Per-channel CV registers: wanted from set cv, sent from a sent frame
  for (genvar i = 0; i < CvChannels; i++) begin : g_cv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_wanted_q[i] <= CvWantedReset;
        cv_sent_q[i]   <= CvSentReset;
      end else if (commit_i) begin
        if (cmd_e'(item_i.command) == CMD_SET_CV && set_ch_ok &&
            32'(item_i.channel) == i) begin
          cv_wanted_q[i] <= item_i.value;
        end
        if (cv_send && 32'(tick_ch) == i) begin
          cv_sent_q[i] <= cv_cur;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cv_gate_dac_refresh_scheduler_top.sv
// cv_gate_dac_refresh_scheduler_top: command input register, scheduler core
// and frame output register. Depends on cgdrs_pkg, cgdrs_cmd_if,
// cgdrs_frame_if and cgdrs_core.
//
//   channel   dir   transaction   fields
//   cmd_i     in    command       command, channel, value, link_ready
//   frame_o   out   link frame    target_select, first_byte, second_byte
//
// One command is taken every cycle unless the held command stalls; a tick's
// frame passes the input register, then the output register.
// A frame waiting in the output register stalls only a command that makes a
// new frame; set commands and quiet ticks still pass.
// After reset the phase is zero and every sent copy differs from its wanted
// copy, so the first eight link-ready ticks refresh every DAC channel and gates.
`default_nettype none

module cv_gate_dac_refresh_scheduler_top #(
  parameter int unsigned CvChannels = cgdrs_pkg::CvChannelsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cgdrs_cmd_if.sink    cmd_i,
  cgdrs_frame_if.source frame_o
);
  import cgdrs_pkg::*;

  logic    in_valid_q;
  cmd_t    in_q;
  logic    out_valid_q;
  frame_t  out_q;
  result_t result;
  logic    out_free;
  logic    commit;
  logic    take;

  // Commit the held command unless its frame has nowhere to go
  assign out_free = !out_valid_q || frame_o.ready;
  assign commit   = in_valid_q && (!result.valid || out_free);
  assign take     = cmd_i.valid && cmd_i.ready;

  assign cmd_i.ready = !in_valid_q || commit;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (commit) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.command    <= cmd_i.command;
      in_q.channel    <= cmd_i.channel;
      in_q.value      <= cmd_i.value;
      in_q.link_ready <= cmd_i.link_ready;
    end
  end

  cgdrs_core #(
    .CvChannels(CvChannels)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_q),
    .commit_i (commit),
    .result_o (result)
  );

  // Output register: load a new frame, drop one that was taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (frame_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && result.valid) begin
      out_q <= result.frame;
    end
  end

  assign frame_o.valid         = out_valid_q;
  assign frame_o.target_select = out_q.target_select;
  assign frame_o.first_byte    = out_q.first_byte;
  assign frame_o.second_byte   = out_q.second_byte;

endmodule

`default_nettype wire
